[rtl/lmt_pkg.sv]
// lmt_pkg: shared types and codes of the landmark track table.
// Used by the top level and the bench; depends on nothing.
`timescale 1ns / 1ps

package lmt_pkg;

    // operation codes of an input beat
    localparam logic [1:0] OP_DET = 2'd0;
    localparam logic [1:0] OP_ODO = 2'd1;
    localparam logic [1:0] OP_VEL = 2'd2;
    localparam logic [1:0] OP_RSV = 2'd3;

    // event codes of a result beat
    localparam logic [1:0] EV_NEW  = 2'd0;
    localparam logic [1:0] EV_PASS = 2'd1;
    localparam logic [1:0] EV_STOP = 2'd2;
    localparam logic [1:0] EV_DROP = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_THR     = 2'd0;
    localparam logic [1:0] REG_MAX_SGN = 2'd1;
    localparam logic [1:0] REG_MIN_SGN = 2'd2;

    // register reset values
    localparam logic [30:0] THR_RST     = 31'd196608;
    localparam logic [7:0]  MAX_SGN_RST = 8'd0;
    localparam logic [7:0]  MIN_SGN_RST = 8'd1;

    // at most this many passed events per pose beat
    localparam int          MAX_RES = 16;
    localparam int          NW      = 5;

    // one stored object
    typedef struct packed {
        logic [7:0]  obj_type;
        logic [15:0] obj_id;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } t_entry;

    // one result beat
    typedef struct packed {
        logic [1:0] event_res;
        t_entry     ent;
        logic       last;
    } t_res;

endpackage

[rtl/lmt_in_if.sv]
// lmt_in_if: input channel of the landmark track table.
// Carries op, detection, pose and velocity fields; no dependencies.
`timescale 1ns / 1ps

interface lmt_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic [7:0]         obj_type;
    logic [15:0]        obj_id;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [31:0] velocity;

    modport source (output valid, op, obj_type, obj_id, pos_x, pos_y, pos_z,
                    quat_w, quat_x, quat_y, quat_z, velocity, input ready);
    modport sink   (input valid, op, obj_type, obj_id, pos_x, pos_y, pos_z,
                    quat_w, quat_x, quat_y, quat_z, velocity, output ready);
endinterface

[rtl/lmt_out_if.sv]
// lmt_out_if: result channel of the landmark track table.
// Carries event code, object fields and last flag; no dependencies.
`timescale 1ns / 1ps

interface lmt_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         event_res;
    logic [7:0]         out_type;
    logic [15:0]        out_id;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               last;

    modport source (output valid, event_res, out_type, out_id, out_x, out_y,
                    out_z, last, input ready);
    modport sink   (input valid, event_res, out_type, out_id, out_x, out_y,
                    out_z, last, output ready);
endinterface

[rtl/lmt_cfg_if.sv]
// lmt_cfg_if: register write channel of the landmark track table.
// Carries register index and write data; no dependencies.
`timescale 1ns / 1ps

interface lmt_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  reg_index;
    logic [31:0] wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface

[rtl/landmark_track_table.sv]
// landmark_track_table: object table with match, append and pass-by removal.
// Depends on lmt_pkg and the interfaces lmt_in_if, lmt_out_if, lmt_cfg_if.
`timescale 1ns / 1ps

// The table sits in one synchronous memory; detection and pose beats walk it
// one entry at a time through the single read port. A detection checks entries
// by type and id and runs the distance test on those that need it; a pose beat
// runs the behind test on each stored entry, sharing the one 34x33 multiplier
// over its three axes. New input is taken only when the previous beat is
// finished; a result waiting in the output register stalls a beat only at the
// point where its next result is due. No clearing pass runs after reset.
module landmark_track_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    lmt_in_if.sink   i_in,
    lmt_cfg_if.sink  i_cfg,
    lmt_out_if.source o_res
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int NW_L = lmt_pkg::NW;

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b00000000001,
        ST_TSQ    = 11'b00000000010,
        ST_COEF   = 11'b00000000100,
        ST_RD     = 11'b00000001000,
        ST_CHK    = 11'b00000010000,
        ST_DIST   = 11'b00000100000,
        ST_APPEND = 11'b00001000000,
        ST_OMUL   = 11'b00010000000,
        ST_ODEC   = 11'b00100000000,
        ST_OEND   = 11'b01000000000,
        ST_VEL    = 11'b10000000000
    } t_state;

    // control state
    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_k, n_k;
    logic [CW-1:0] r_keep, n_keep;
    logic [NW_L-1:0] r_n, n_n;
    logic [2:0] r_step, n_step;
    logic r_armed, n_armed;
    logic r_pend, n_pend;
    logic r_ov;

    // configuration
    logic [30:0] r_thr;
    logic [7:0]  r_max_sgn, r_min_sgn;

    // latched beat
    logic [1:0]         r_op;
    lmt_pkg::t_entry    r_obj;
    logic signed [15:0] r_qw, r_qx, r_qy, r_qz;
    logic signed [31:0] r_vel;

    // datapath registers
    logic [61:0]        r_tt, n_tt;
    logic [63:0]        r_prod, n_prod;
    logic [63:0]        r_acc, n_acc;
    logic               r_fail, n_fail;
    logic signed [33:0] r_c0, n_c0, r_c1, n_c1, r_c2, n_c2;
    logic signed [66:0] r_oprod, n_oprod;
    logic signed [68:0] r_oacc, n_oacc;
    lmt_pkg::t_entry    r_pend_ent, n_pend_ent;
    lmt_pkg::t_res      r_oitem;

    // memory and its ports
    lmt_pkg::t_entry r_mem [TABLE_DEPTH];
    lmt_pkg::t_entry r_rd;
    logic            mem_we, rd_en;
    logic [AW-1:0]   mem_wa, rd_addr;
    lmt_pkg::t_entry mem_wd;

    // output push
    logic          push, can_push;
    lmt_pkg::t_res push_item;

    // combinational helpers
    logic               in_acc, k_last, full;
    logic               type_eq, id_eq, sp_both;
    logic signed [31:0] ax_p, ax_e;
    logic signed [32:0] ax_d;
    logic [32:0]        ax_mag;
    logic [61:0]        ax_sq;
    logic               ax_fail;
    logic [63:0]        dsum;
    logic signed [15:0] qa, qb;
    logic signed [31:0] qp;
    logic signed [33:0] qterm;
    logic signed [33:0] om_c;
    logic signed [32:0] om_d;
    logic signed [68:0] osum;
    logic               behind;

    assign in_acc     = i_in.valid && i_in.ready;
    assign i_in.ready = i_rst_n && (r_state == ST_IDLE);
    assign i_cfg.ready = i_rst_n;
    assign can_push   = !r_ov || o_res.ready;
    assign k_last     = ((r_k + CW'(1)) == r_count);
    assign full       = (r_count >= CW'(TABLE_DEPTH));

    // type, id and speed sign checks against the read entry
    assign type_eq = (r_rd.obj_type == r_obj.obj_type);
    assign id_eq   = (r_rd.obj_id == r_obj.obj_id);
    assign sp_both = ((r_rd.obj_type == r_max_sgn) || (r_rd.obj_type == r_min_sgn))
                  && ((r_obj.obj_type == r_max_sgn) || (r_obj.obj_type == r_min_sgn));

    // one axis of the distance test per step
    always_comb begin
        unique case (r_step[1:0])
            2'd0:    begin ax_p = r_obj.x; ax_e = r_rd.x; end
            2'd1:    begin ax_p = r_obj.y; ax_e = r_rd.y; end
            default: begin ax_p = r_obj.z; ax_e = r_rd.z; end
        endcase
        ax_d    = 33'(ax_p) - 33'(ax_e);
        ax_mag  = ax_d[32] ? (33'd0 - ax_d) : ax_d;
        ax_sq   = ax_mag[30:0] * ax_mag[30:0];
        ax_fail = (ax_mag >= {2'b00, r_thr});
    end
    assign dsum = r_acc + r_prod;

    // quaternion products, one per step
    always_comb begin
        unique case (r_step)
            3'd0:    begin qa = r_qw; qb = r_qw; end
            3'd1:    begin qa = r_qx; qb = r_qx; end
            3'd2:    begin qa = r_qy; qb = r_qy; end
            3'd3:    begin qa = r_qz; qb = r_qz; end
            3'd4:    begin qa = r_qx; qb = r_qy; end
            3'd5:    begin qa = r_qw; qb = r_qz; end
            3'd6:    begin qa = r_qx; qb = r_qz; end
            default: begin qa = r_qw; qb = r_qy; end
        endcase
        qp    = qa * qb;
        qterm = (r_step >= 3'd4) ? (34'(qp) <<< 1) : 34'(qp);
    end

    // behind test operands, one axis per step
    always_comb begin
        unique case (r_step[1:0])
            2'd0:    begin om_c = r_c0; om_d = 33'($signed(r_rd.x)) - 33'($signed(r_obj.x)); end
            2'd1:    begin om_c = r_c1; om_d = 33'($signed(r_rd.y)) - 33'($signed(r_obj.y)); end
            default: begin om_c = r_c2; om_d = 33'($signed(r_rd.z)) - 33'($signed(r_obj.z)); end
        endcase
    end
    assign osum   = r_oacc + 69'(r_oprod);
    assign behind = osum[68] && (r_n < NW_L'(lmt_pkg::MAX_RES));

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_k        = r_k;
        n_keep     = r_keep;
        n_n        = r_n;
        n_step     = r_step;
        n_armed    = r_armed;
        n_pend     = r_pend;
        n_tt       = r_tt;
        n_prod     = r_prod;
        n_acc      = r_acc;
        n_fail     = r_fail;
        n_c0       = r_c0;
        n_c1       = r_c1;
        n_c2       = r_c2;
        n_oprod    = r_oprod;
        n_oacc     = r_oacc;
        n_pend_ent = r_pend_ent;
        mem_we     = 1'b0;
        mem_wa     = r_k[AW-1:0];
        mem_wd     = r_obj;
        rd_en      = 1'b0;
        rd_addr    = r_k[AW-1:0];
        push       = 1'b0;
        push_item  = '{event_res: lmt_pkg::EV_NEW, ent: r_obj, last: 1'b1};

        unique case (r_state)
            ST_IDLE: begin
                n_step = '0;
                if (in_acc) begin
                    unique case (i_in.op)
                        lmt_pkg::OP_DET: n_state = ST_TSQ;
                        lmt_pkg::OP_ODO: begin
                            n_state = ST_COEF;
                            n_c0 = '0;
                            n_c1 = '0;
                            n_c2 = '0;
                        end
                        lmt_pkg::OP_VEL: n_state = ST_VEL;
                        default:         n_state = ST_IDLE;
                    endcase
                end
            end
            ST_TSQ: begin
                n_tt = r_thr * r_thr;
                n_k  = '0;
                n_state = (r_count == '0) ? ST_APPEND : ST_RD;
            end
            ST_RD: begin
                rd_en   = 1'b1;
                n_step  = '0;
                n_state = (r_op == lmt_pkg::OP_DET) ? ST_CHK : ST_OMUL;
            end
            ST_CHK: begin
                if (type_eq && id_eq && (r_obj.obj_id != '0)) begin
                    // overwrite matched entry
                    mem_we  = 1'b1;
                    n_state = ST_IDLE;
                end else if ((type_eq && id_eq) || (!type_eq && sp_both)) begin
                    n_step  = '0;
                    n_state = ST_DIST;
                end else if (k_last) begin
                    n_state = ST_APPEND;
                end else begin
                    n_k     = r_k + CW'(1);
                    n_state = ST_RD;
                end
            end
            ST_DIST: begin
                if (r_step != 3'd3) begin
                    n_prod = {2'b00, ax_sq};
                    n_acc  = (r_step == 3'd0) ? 64'd0 : dsum;
                    n_fail = ((r_step == 3'd0) ? 1'b0 : r_fail) | ax_fail;
                    n_step = r_step + 3'd1;
                end else if (!r_fail && (dsum < {2'b00, r_tt})) begin
                    mem_we  = 1'b1;
                    n_state = ST_IDLE;
                end else if (k_last) begin
                    n_state = ST_APPEND;
                end else begin
                    n_k     = r_k + CW'(1);
                    n_state = ST_RD;
                end
            end
            ST_APPEND: begin
                if (can_push) begin
                    push = 1'b1;
                    if (full) begin
                        push_item.event_res = lmt_pkg::EV_DROP;
                    end else begin
                        mem_we  = 1'b1;
                        mem_wa  = r_count[AW-1:0];
                        n_count = r_count + CW'(1);
                    end
                    n_state = ST_IDLE;
                end
            end
            ST_COEF: begin
                if (r_step < 3'd4) begin
                    n_c0 = (r_step < 3'd2) ? (r_c0 + qterm) : (r_c0 - qterm);
                end else if (r_step < 3'd6) begin
                    n_c1 = r_c1 + qterm;
                end else if (r_step == 3'd6) begin
                    n_c2 = r_c2 + qterm;
                end else begin
                    n_c2 = r_c2 - qterm;
                end
                n_step = r_step + 3'd1;
                if (r_step == 3'd7) begin
                    n_k    = '0;
                    n_keep = '0;
                    n_n    = '0;
                    n_pend = 1'b0;
                    n_state = (r_count == '0) ? ST_IDLE : ST_RD;
                end
            end
            ST_OMUL: begin
                n_oprod = om_c * om_d;
                n_oacc  = (r_step == 3'd0) ? 69'sd0 : osum;
                n_step  = r_step + 3'd1;
                if (r_step == 3'd2) begin
                    n_state = ST_ODEC;
                end
            end
            ST_ODEC: begin
                if (!(behind && r_pend && !can_push)) begin
                    if (behind) begin
                        // hold the newest passed entry until its last flag is known
                        if (r_pend) begin
                            push = 1'b1;
                            push_item = '{event_res: lmt_pkg::EV_PASS, ent: r_pend_ent,
                                          last: 1'b0};
                        end
                        n_pend     = 1'b1;
                        n_pend_ent = r_rd;
                        n_n        = r_n + NW_L'(1);
                    end else begin
                        // compact kept entry
                        mem_we = 1'b1;
                        mem_wa = r_keep[AW-1:0];
                        mem_wd = r_rd;
                        n_keep = r_keep + CW'(1);
                    end
                    if (k_last) begin
                        n_state = ST_OEND;
                    end else begin
                        n_k     = r_k + CW'(1);
                        n_state = ST_RD;
                    end
                end
            end
            ST_OEND: begin
                n_count = r_keep;
                if (!r_pend) begin
                    n_state = ST_IDLE;
                end else if (can_push) begin
                    push = 1'b1;
                    push_item = '{event_res: lmt_pkg::EV_PASS, ent: r_pend_ent, last: 1'b1};
                    n_pend  = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            ST_VEL: begin
                if (r_vel != '0) begin
                    n_armed = 1'b1;
                    n_state = ST_IDLE;
                end else if (!r_armed) begin
                    n_state = ST_IDLE;
                end else if (can_push) begin
                    push = 1'b1;
                    push_item = '{event_res: lmt_pkg::EV_STOP, ent: '0, last: 1'b1};
                    n_armed = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_k       <= '0;
            r_keep    <= '0;
            r_n       <= '0;
            r_step    <= '0;
            r_armed   <= 1'b1;
            r_pend    <= 1'b0;
            r_ov      <= 1'b0;
            r_thr     <= lmt_pkg::THR_RST;
            r_max_sgn <= lmt_pkg::MAX_SGN_RST;
            r_min_sgn <= lmt_pkg::MIN_SGN_RST;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_k     <= n_k;
            r_keep  <= n_keep;
            r_n     <= n_n;
            r_step  <= n_step;
            r_armed <= n_armed;
            r_pend  <= n_pend;
            if (push) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
            if (i_cfg.valid) begin
                unique case (i_cfg.reg_index)
                    lmt_pkg::REG_THR:     r_thr     <= i_cfg.wdata[30:0];
                    lmt_pkg::REG_MAX_SGN: r_max_sgn <= i_cfg.wdata[7:0];
                    lmt_pkg::REG_MIN_SGN: r_min_sgn <= i_cfg.wdata[7:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op  <= i_in.op;
            r_obj <= '{obj_type: i_in.obj_type, obj_id: i_in.obj_id,
                       x: i_in.pos_x, y: i_in.pos_y, z: i_in.pos_z};
            r_qw  <= i_in.quat_w;
            r_qx  <= i_in.quat_x;
            r_qy  <= i_in.quat_y;
            r_qz  <= i_in.quat_z;
            r_vel <= i_in.velocity;
        end
        r_tt       <= n_tt;
        r_prod     <= n_prod;
        r_acc      <= n_acc;
        r_fail     <= n_fail;
        r_c0       <= n_c0;
        r_c1       <= n_c1;
        r_c2       <= n_c2;
        r_oprod    <= n_oprod;
        r_oacc     <= n_oacc;
        r_pend_ent <= n_pend_ent;
        if (push) begin
            r_oitem <= push_item;
        end
    end

    // table memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // result channel
    assign o_res.valid     = r_ov;
    assign o_res.event_res = r_oitem.event_res;
    assign o_res.out_type  = r_oitem.ent.obj_type;
    assign o_res.out_id    = r_oitem.ent.obj_id;
    assign o_res.out_x     = r_oitem.ent.x;
    assign o_res.out_y     = r_oitem.ent.y;
    assign o_res.out_z     = r_oitem.ent.z;
    assign o_res.last      = r_oitem.last;

    // table never overfills
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    // compaction never overtakes the scan
    a_keep_le_k: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ODEC) |-> (r_keep <= r_k))
        else $error("compaction index ahead of scan index");

    // passed events stay within the per-beat limit
    a_n_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= NW_L'(lmt_pkg::MAX_RES))
        else $error("too many passed events");

    // no held passed entry survives the end of a beat
    a_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend)
        else $error("passed entry left pending");

    // a push never overwrites a waiting result
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (!r_ov || o_res.ready))
        else $error("result register overwritten");

endmodule

[tb/tb_lmt_scoreboard.sv]
// tb_lmt_scoreboard: expected-event store of the landmark track table bench.
// Holds its own copy of the object table and registers; depends on lmt_pkg.
`timescale 1ns / 1ps

class lmt_event_board;

    // one expected event beat
    typedef struct {
        logic [1:0]  ev;
        logic [7:0]  otype;
        logic [15:0] oid;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        last;
    } t_event;

    // shadow registers
    logic [30:0] thr;
    logic [7:0]  max_sign;
    logic [7:0]  min_sign;

    // shadow table
    logic [7:0]  tab_type [16];
    logic [15:0] tab_id   [16];
    logic [31:0] tab_x    [16];
    logic [31:0] tab_y    [16];
    logic [31:0] tab_z    [16];
    int          tab_cnt;
    bit          stop_armed;

    t_event      pending_events[$];
    int          mismatches;

    function new();
        thr        = lmt_pkg::THR_RST;
        max_sign   = lmt_pkg::MAX_SGN_RST;
        min_sign   = lmt_pkg::MIN_SGN_RST;
        tab_cnt    = 0;
        stop_armed = 1'b1;
        mismatches = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
        case (idx)
            lmt_pkg::REG_THR:     thr      = data[30:0];
            lmt_pkg::REG_MAX_SGN: max_sign = data[7:0];
            lmt_pkg::REG_MIN_SGN: min_sign = data[7:0];
            default: ;
        endcase
    endfunction

    function void push_event(logic [1:0] ev, logic [7:0] ty, logic [15:0] id,
                             logic [31:0] x, logic [31:0] y, logic [31:0] z);
        t_event e;
        e.ev = ev; e.otype = ty; e.oid = id;
        e.x = x; e.y = y; e.z = z; e.last = 1'b0;
        pending_events = {pending_events, e};
    endfunction

    // every axis below threshold and squared distance strictly below squared threshold
    function bit near_entry(int k, logic [31:0] x, logic [31:0] y, logic [31:0] z);
        longint d[3];
        longint unsigned a, t, sum;
        d[0] = longint'($signed(x)) - longint'($signed(tab_x[k]));
        d[1] = longint'($signed(y)) - longint'($signed(tab_y[k]));
        d[2] = longint'($signed(z)) - longint'($signed(tab_z[k]));
        t = thr;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            a = (d[i] < 0) ? -d[i] : d[i];
            if (a >= t) return 1'b0;
            sum += a * a;
        end
        return sum < t * t;
    endfunction

    function bit is_sign(logic [7:0] ty);
        return ty == max_sign || ty == min_sign;
    endfunction

    // note one accepted input beat and queue the events it causes
    function void note_input(logic [1:0] op, logic [7:0] ty, logic [15:0] id,
                             logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic signed [15:0] qw, logic signed [15:0] qx,
                             logic signed [15:0] qy, logic signed [15:0] qz,
                             logic signed [31:0] vel);
        int start, keep, n;
        bit hit;
        longint c0, c1, c2;
        logic signed [127:0] acc;
        start = pending_events.size();
        n = 0;
        case (op)
            lmt_pkg::OP_DET: begin
                hit = 1'b0;
                for (int k = 0; k < tab_cnt && !hit; k++) begin
                    if (tab_type[k] == ty)
                        hit = (tab_id[k] == id) && (id != 0 || near_entry(k, x, y, z));
                    else
                        hit = is_sign(tab_type[k]) && is_sign(ty) && near_entry(k, x, y, z);
                    if (hit) begin
                        tab_type[k] = ty; tab_id[k] = id;
                        tab_x[k] = x; tab_y[k] = y; tab_z[k] = z;
                    end
                end
                if (!hit) begin
                    if (tab_cnt >= 16) begin
                        push_event(lmt_pkg::EV_DROP, ty, id, x, y, z);
                    end else begin
                        tab_type[tab_cnt] = ty; tab_id[tab_cnt] = id;
                        tab_x[tab_cnt] = x; tab_y[tab_cnt] = y; tab_z[tab_cnt] = z;
                        tab_cnt++;
                        push_event(lmt_pkg::EV_NEW, ty, id, x, y, z);
                    end
                end
            end
            lmt_pkg::OP_ODO: begin
                c0 = longint'(qw) * qw + longint'(qx) * qx - longint'(qy) * qy
                     - longint'(qz) * qz;
                c1 = 2 * (longint'(qx) * qy + longint'(qw) * qz);
                c2 = 2 * (longint'(qx) * qz - longint'(qw) * qy);
                keep = 0;
                for (int k = 0; k < tab_cnt; k++) begin
                    acc = 128'(signed'(c0)) *
                          128'(signed'(longint'($signed(tab_x[k])) - longint'($signed(x))))
                        + 128'(signed'(c1)) *
                          128'(signed'(longint'($signed(tab_y[k])) - longint'($signed(y))))
                        + 128'(signed'(c2)) *
                          128'(signed'(longint'($signed(tab_z[k])) - longint'($signed(z))));
                    if (acc < 0 && n < lmt_pkg::MAX_RES) begin
                        push_event(lmt_pkg::EV_PASS, tab_type[k], tab_id[k],
                                   tab_x[k], tab_y[k], tab_z[k]);
                        n++;
                    end else begin
                        tab_type[keep] = tab_type[k]; tab_id[keep] = tab_id[k];
                        tab_x[keep] = tab_x[k]; tab_y[keep] = tab_y[k];
                        tab_z[keep] = tab_z[k];
                        keep++;
                    end
                end
                tab_cnt = keep;
            end
            lmt_pkg::OP_VEL: begin
                if (vel == 0) begin
                    if (stop_armed) push_event(lmt_pkg::EV_STOP, 8'd0, 16'd0, 0, 0, 0);
                    stop_armed = 1'b0;
                end else begin
                    stop_armed = 1'b1;
                end
            end
            default: ;
        endcase
        if (pending_events.size() > start)
            pending_events[pending_events.size() - 1].last = 1'b1;
    endfunction

    // compare one accepted result beat with the oldest expectation
    function void check_result(logic [1:0] ev, logic [7:0] ty, logic [15:0] id,
                               logic [31:0] x, logic [31:0] y, logic [31:0] z,
                               logic last);
        t_event e;
        if (pending_events.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected event beat ev=%0d type=%0d id=%0d", ev, ty, id);
            return;
        end
        e = pending_events.pop_front();
        if (ev !== e.ev || ty !== e.otype || id !== e.oid || x !== e.x || y !== e.y
            || z !== e.z || last !== e.last) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("event mismatch: exp ev=%0d type=%0d id=%0d x=%h y=%h z=%h last=%b",
                         e.ev, e.otype, e.oid, e.x, e.y, e.z, e.last);
                $display("                got ev=%0d type=%0d id=%0d x=%h y=%h z=%h last=%b",
                         ev, ty, id, x, y, z, last);
            end
        end
    endfunction

endclass

[tb/tb.sv]
// tb: self-checking bench of landmark_track_table with random bursts and stalls.
// Depends on lmt_pkg, the channel interfaces, the block and lmt_event_board.
`timescale 1ns / 1ps

module tb;

    localparam int IDLE_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;

    lmt_in_if  in_ch();
    lmt_cfg_if cfg_ch();
    lmt_out_if res_ch();

    landmark_track_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .i_cfg   (cfg_ch.sink),
        .o_res   (res_ch.source)
    );

    lmt_event_board board;
    int  idle_cycles;
    bit  stall_on;
    bit  sender_on;
    int  stall_phase;

    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    // receiver stall pattern, result checking and watchdog
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (!stall_on) begin
            res_ch.ready <= 1'b1;
        end else begin
            res_ch.ready <= (stall_phase % 7 < 4) ? ($urandom_range(0, 3) != 0)
                                                 : ($urandom_range(0, 2) == 0);
        end
        if (i_rst_n && res_ch.valid && res_ch.ready)
            board.check_result(res_ch.event_res, res_ch.out_type, res_ch.out_id,
                               res_ch.out_x, res_ch.out_y, res_ch.out_z, res_ch.last);
        if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL landmark_track_table");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.wdata     <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        board.write_reg(idx, data);
        cfg_ch.valid <= 1'b0;
    endtask

    // send one beat; the sender may gap before it
    task automatic send_beat(logic [1:0] op, logic [7:0] ty, logic [15:0] id,
                             logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [15:0] qw, logic [15:0] qx, logic [15:0] qy,
                             logic [15:0] qz, logic [31:0] vel);
        int gap;
        if (sender_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.op <= op; in_ch.obj_type <= ty; in_ch.obj_id <= id;
        in_ch.pos_x <= x; in_ch.pos_y <= y; in_ch.pos_z <= z;
        in_ch.quat_w <= qw; in_ch.quat_x <= qx; in_ch.quat_y <= qy; in_ch.quat_z <= qz;
        in_ch.velocity <= vel;
        do @(posedge i_clk); while (!in_ch.ready);
        board.note_input(op, ty, id, x, y, z, qw, qx, qy, qz, vel);
    endtask

    task automatic drop_valid();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic det(logic [7:0] ty, logic [15:0] id, logic [31:0] x,
                       logic [31:0] y, logic [31:0] z);
        send_beat(lmt_pkg::OP_DET, ty, id, x, y, z, 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), $urandom);
    endtask

    task automatic pose(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [15:0] qw,
                        logic [15:0] qx, logic [15:0] qy, logic [15:0] qz);
        send_beat(lmt_pkg::OP_ODO, 8'($urandom), 16'($urandom), x, y, z, qw, qx, qy, qz,
                  $urandom);
    endtask

    task automatic vel(logic [31:0] v);
        send_beat(lmt_pkg::OP_VEL, 8'($urandom), 16'($urandom), $urandom, $urandom,
                  $urandom, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), v);
    endtask

    // drain all expected events, then let the block settle
    task automatic drain();
        drop_valid();
        while (board.pending_events.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_q();
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    // random object, near the origin unless wide, so matches and passes happen often
    task automatic rand_det(bit wide);
        logic [31:0] x, y, z;
        logic [7:0] ty;
        if (wide) begin
            x = $urandom; y = $urandom; z = $urandom;
        end else begin
            x = 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
            y = 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
            z = 32'($signed($urandom_range(0, 2 << 16)) - (1 << 16));
        end
        ty = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
        det(ty, ($urandom_range(0, 1) == 0) ? 16'd0
                 : (($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 4))),
            x, y, z);
    endtask

    task automatic rand_pose();
        logic [31:0] x;
        x = 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
        case ($urandom_range(0, 5))
            0: pose($urandom, $urandom, $urandom, rand_q(), rand_q(), rand_q(), rand_q());
            1: pose(x, $urandom_range(0, 1 << 16), 0, 16'd0, 16'd0, 16'd0, 16'd0);
            2: pose(x, 0, 0, rand_q(), rand_q(), rand_q(), rand_q());
            default: pose(x, 0, 0, 16'sd16384, 16'd0, 16'd0, 16'd0);
        endcase
    endtask

    initial begin
        board = new();
        i_rst_n = 1'b0;
        idle_cycles = 0;
        stall_on = 1'b0;
        sender_on = 1'b0;
        stall_phase = 0;
        in_ch.valid = 1'b0; in_ch.op = lmt_pkg::OP_DET; in_ch.obj_type = '0;
        in_ch.obj_id = '0;
        in_ch.pos_x = '0; in_ch.pos_y = '0; in_ch.pos_z = '0;
        in_ch.quat_w = '0; in_ch.quat_x = '0; in_ch.quat_y = '0; in_ch.quat_z = '0;
        in_ch.velocity = '0;
        cfg_ch.valid = 1'b0; cfg_ch.reg_index = lmt_pkg::REG_THR; cfg_ch.wdata = '0;
        res_ch.ready = 1'b1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, every op, sign pairs, table fill, stops
        det(8'd5, 16'd7, 32'h7fffffff, 32'h80000000, 32'h0);
        det(8'd5, 16'd7, 32'h0, 32'h0, 32'h0);
        det(8'd255, 16'hffff, 32'h80000000, 32'h7fffffff, 32'hffffffff);
        det(8'd9, 16'd0, 32'h10000, 0, 0);
        det(8'd9, 16'd0, 32'h20000, 0, 0);
        det(8'd9, 16'd0, 32'h50000, 0, 0);
        det(8'd0, 16'd0, 32'h100000, 0, 0);
        det(8'd1, 16'd3, 32'h110000, 0, 0);
        vel(0); vel(0); vel(32'hffffffff); vel(0); vel(1); vel(32'h7fffffff);
        send_beat(lmt_pkg::OP_RSV, 8'd1, 16'd1, 1, 1, 1, 16'd1, 16'd1, 16'd1, 16'd1, 0);
        pose(0, 0, 0, 16'd0, 16'd0, 16'd0, 16'd0);
        for (int i = 0; i < 12; i++) det(8'd20, 16'(i + 1), 32'(-i << 16), 0, 0);
        det(8'd21, 16'd1, 0, 0, 0);
        pose(32'h40000, 0, 0, 16'sd16384, 16'd0, 16'd0, 16'd0);
        pose(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'sd16384, 16'sd16384,
             -16'sd16384, -16'sd16384);
        pose(32'h80000000, 0, 0, -16'sd16384, 16'd0, 16'd0, 16'd0);
        drain();

        // register settings: extremes and a few midpoints, random traffic each
        sender_on = 1'b1;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(lmt_pkg::REG_THR, 32'd0);
                    write_reg(lmt_pkg::REG_MAX_SGN, 32'd255);
                    write_reg(lmt_pkg::REG_MIN_SGN, 32'd0);
                end
                1: begin
                    write_reg(lmt_pkg::REG_THR, 32'h7fffffff);
                    write_reg(lmt_pkg::REG_MAX_SGN, 32'd2);
                    write_reg(lmt_pkg::REG_MIN_SGN, 32'd3);
                end
                2: begin
                    write_reg(lmt_pkg::REG_THR, 32'h30000);
                    write_reg(lmt_pkg::REG_MAX_SGN, 32'd1);
                    write_reg(lmt_pkg::REG_MIN_SGN, 32'd1);
                end
                3: begin
                    write_reg(lmt_pkg::REG_THR, $urandom);
                    write_reg(lmt_pkg::REG_MAX_SGN, $urandom);
                    write_reg(lmt_pkg::REG_MIN_SGN, $urandom);
                end
                4: begin
                    write_reg(lmt_pkg::REG_THR, 32'h80000);
                    write_reg(lmt_pkg::REG_MAX_SGN, 32'd3);
                    write_reg(lmt_pkg::REG_MIN_SGN, 32'd4);
                end
                default: begin
                    write_reg(lmt_pkg::REG_THR, 32'h20000);
                    write_reg(lmt_pkg::REG_MAX_SGN, 32'd0);
                    write_reg(lmt_pkg::REG_MIN_SGN, 32'd255);
                end
            endcase
            stall_on = (ph % 2 == 0);
            for (int i = 0; i < 60; i++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: rand_det($urandom_range(0, 7) == 0);
                    5, 6: rand_pose();
                    7: vel(($urandom_range(0, 2) == 0) ? 32'd0 : $urandom);
                    8: if ($urandom_range(0, 3) == 0)
                           send_beat(lmt_pkg::OP_RSV, 8'($urandom), 16'($urandom),
                                     $urandom, $urandom, $urandom, 16'($urandom),
                                     16'($urandom), 16'($urandom), 16'($urandom),
                                     $urandom);
                       else rand_det(1'b0);
                    default: if (i == 30) begin
                        // hold off until all events are in
                        drop_valid();
                        while (board.pending_events.size() != 0) @(posedge i_clk);
                    end else rand_det(1'b0);
                endcase
            end
            drain();
        end

        if (board.mismatches == 0 && board.pending_events.size() == 0) begin
            $display("PASS landmark_track_table");
        end else begin
            $display("FAIL landmark_track_table");
        end
        $finish;
    end

endmodule

[landmark_track_table.f]
rtl/lmt_pkg.sv
rtl/lmt_in_if.sv
rtl/lmt_out_if.sv
rtl/lmt_cfg_if.sv
rtl/landmark_track_table.sv
tb/tb_lmt_scoreboard.sv
tb/tb.sv
